// ===== hdl/can_id_interarrival_monitor_assert.svh =====
// ---------------------------------------------------------------------------
// CAN ID inter-arrival monitor: assertion macros
// Immediate-consequence and next-cycle checks, clocked on clk and held off
// while rst is high.
// ---------------------------------------------------------------------------
`ifndef CAN_ID_INTERARRIVAL_MONITOR_ASSERT_SVH
`define CAN_ID_INTERARRIVAL_MONITOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CIIM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CIIM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ciim_pkg.sv =====
// ---------------------------------------------------------------------------
// ciim_pkg
// Types and constants of the CAN ID inter-arrival monitor.
// ---------------------------------------------------------------------------
package ciim_pkg;

  localparam int unsigned ID_W      = 29;
  localparam int unsigned GAP_W     = 31;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned TMO_W     = 16;
  localparam int unsigned LIMIT_W   = 26;
  localparam int unsigned MS_PER_SECOND = 1000;

  // input item actions
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_FRAME = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAND     = 3'd1,
    ST_BACK     = 3'd2,
    ST_FIRST    = 3'd3,
    ST_UNKNOWN  = 3'd4,
    ST_LOADED   = 3'd5,
    ST_REJECTED = 3'd6,
    ST_SILENT   = 3'd7
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD,
    S_EVAL,
    S_LOAD_WR,
    S_GAP,
    S_MIN,
    S_MAX,
    S_LIM,
    S_OUT
  } state_t;

endpackage

// ===== hdl/can_id_interarrival_monitor.sv =====
// ---------------------------------------------------------------------------
// can_id_interarrival_monitor
// Watches a table of CAN identifiers, checks the gap between frames of each
// against its allowed band and reports identifiers that have gone silent.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid / in_stall  | action, can_id, time_ms,
//          |           |                      | min_gap_ms, max_gap_ms
//  out     | output    | out_valid / out_stall| status, reported_id,
//          |           |                      | elapsed_ms, last_result
//  cfg     | input     | cfg_valid / cfg_ready| cfg_data (timeout_seconds)
//
//  One item at a time; in_stall is high from acceptance until it is done. The
//  table walk sets the time: load and frame items read and evaluate each entry
//  visited (a gap check adds gap, min and max states); a tick reads, evaluates
//  and limit-checks each entry in up to two walks, all through one shared
//  64-bit subtractor. A stalled result holds the sequencer in place. rst is
//  synchronous, empties the table and sets a 1 s timeout; no clearing pass.
// ---------------------------------------------------------------------------
module can_id_interarrival_monitor #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // input items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  action,
  input  logic [ciim_pkg::ID_W-1:0]   can_id,
  input  logic [ciim_pkg::TIME_W-1:0] time_ms,
  input  logic [ciim_pkg::GAP_W-1:0]  min_gap_ms,
  input  logic [ciim_pkg::GAP_W-1:0]  max_gap_ms,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  status,
  output logic [ciim_pkg::ID_W-1:0]   reported_id,
  output logic [ciim_pkg::TIME_W-1:0] elapsed_ms,
  output logic                        last_result,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ciim_pkg::TMO_W-1:0]  cfg_data
);

  `include "can_id_interarrival_monitor_assert.svh"

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // table memories
  logic [ciim_pkg::ID_W-1:0]   id_mem   [TABLE_DEPTH];
  logic [ciim_pkg::GAP_W-1:0]  min_mem  [TABLE_DEPTH];
  logic [ciim_pkg::GAP_W-1:0]  max_mem  [TABLE_DEPTH];
  logic [ciim_pkg::TIME_W-1:0] last_mem [TABLE_DEPTH];

  logic [ciim_pkg::ID_W-1:0]   rd_id;
  logic [ciim_pkg::GAP_W-1:0]  rd_min;
  logic [ciim_pkg::GAP_W-1:0]  rd_max;
  logic [ciim_pkg::TIME_W-1:0] rd_last;

  logic                        mem_we;
  logic                        mem_load;
  logic [IW-1:0]               mem_wa;
  logic [ciim_pkg::TIME_W-1:0] mem_wlast;

  // control registers
  ciim_pkg::state_t state, state_next;
  logic [CW-1:0]    count, count_next;
  logic             scan_en, scan_en_next;
  logic [ciim_pkg::LIMIT_W-1:0] limit_ms, limit_ms_next;

  // item and work registers
  ciim_pkg::action_t           act, act_next;
  logic [ciim_pkg::ID_W-1:0]   cid, cid_next;
  logic [ciim_pkg::TIME_W-1:0] now, now_next;
  logic [ciim_pkg::GAP_W-1:0]  mn, mn_next;
  logic [ciim_pkg::GAP_W-1:0]  mx, mx_next;
  logic [IW-1:0]               idx, idx_next;
  logic [CW-1:0]               hits, hits_next;
  logic                        pass2, pass2_next;
  logic                        report, report_next;
  logic                        band, band_next;
  logic [ciim_pkg::TIME_W-1:0] acc, acc_next;

  // result registers
  ciim_pkg::status_t           o_status, o_status_next;
  logic [ciim_pkg::ID_W-1:0]   o_id, o_id_next;
  logic [ciim_pkg::TIME_W-1:0] o_elapsed, o_elapsed_next;
  logic                        o_last, o_last_next;

  // shared subtractor
  logic [ciim_pkg::TIME_W-1:0] sub_a, sub_b, sub_diff;
  logic                        sub_borrow;
  logic                        last_entry;
  logic                        hit;

  assign {sub_borrow, sub_diff} = {1'b0, sub_a} - {1'b0, sub_b};
  assign last_entry = ((CW'(idx) + CW'(1)) == count);
  assign hit        = sub_borrow && (rd_last != '0);

  // ports
  assign in_stall    = (state != ciim_pkg::S_IDLE);
  assign out_valid   = (state == ciim_pkg::S_OUT);
  assign cfg_ready   = (state == ciim_pkg::S_IDLE);
  assign status      = o_status;
  assign reported_id = o_id;
  assign elapsed_ms  = o_elapsed;
  assign last_result = o_last;

  // table write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      last_mem[mem_wa] <= mem_wlast;
    end
    if (mem_load) begin
      id_mem[mem_wa]  <= cid;
      min_mem[mem_wa] <= mn;
      max_mem[mem_wa] <= mx;
    end
    rd_id   <= id_mem[idx];
    rd_min  <= min_mem[idx];
    rd_max  <= max_mem[idx];
    rd_last <= last_mem[idx];
  end

  // state and register update
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ciim_pkg::S_IDLE;
      count    <= '0;
      scan_en  <= 1'b0;
      limit_ms <= ciim_pkg::LIMIT_W'(ciim_pkg::MS_PER_SECOND);
    end else begin
      state    <= state_next;
      count    <= count_next;
      scan_en  <= scan_en_next;
      limit_ms <= limit_ms_next;
    end
    act       <= act_next;
    cid       <= cid_next;
    now       <= now_next;
    mn        <= mn_next;
    mx        <= mx_next;
    idx       <= idx_next;
    hits      <= hits_next;
    pass2     <= pass2_next;
    report    <= report_next;
    band      <= band_next;
    acc       <= acc_next;
    o_status  <= o_status_next;
    o_id      <= o_id_next;
    o_elapsed <= o_elapsed_next;
    o_last    <= o_last_next;
  end

  // sequencer
  always_comb begin
    state_next     = state;
    count_next     = count;
    scan_en_next   = scan_en;
    limit_ms_next  = limit_ms;
    act_next       = act;
    cid_next       = cid;
    now_next       = now;
    mn_next        = mn;
    mx_next        = mx;
    idx_next       = idx;
    hits_next      = hits;
    pass2_next     = pass2;
    report_next    = report;
    band_next      = band;
    acc_next       = acc;
    o_status_next  = o_status;
    o_id_next      = o_id;
    o_elapsed_next = o_elapsed;
    o_last_next    = o_last;
    sub_a          = '0;
    sub_b          = '0;
    mem_we         = 1'b0;
    mem_load       = 1'b0;
    mem_wa         = idx;
    mem_wlast      = '0;

    // timeout register, written only while idle
    if (cfg_valid && cfg_ready) begin
      limit_ms_next = ciim_pkg::LIMIT_W'(cfg_data) *
                      ciim_pkg::LIMIT_W'(ciim_pkg::MS_PER_SECOND);
    end

    case (state)
      ciim_pkg::S_IDLE: begin
        if (in_valid) begin
          act_next   = ciim_pkg::action_t'(action);
          cid_next   = can_id;
          now_next   = time_ms;
          mn_next    = min_gap_ms;
          mx_next    = max_gap_ms;
          state_next = ciim_pkg::S_DISPATCH;
        end
      end

      // decide what the item needs before any table walk
      ciim_pkg::S_DISPATCH: begin
        idx_next       = '0;
        hits_next      = '0;
        pass2_next     = 1'b0;
        report_next    = 1'b0;
        o_id_next      = cid;
        o_elapsed_next = '0;
        o_last_next    = 1'b1;
        case (act)
          ciim_pkg::ACT_LOAD: begin
            if (mn == '0 || mx == '0 || mn > mx || count == CW'(TABLE_DEPTH)) begin
              o_status_next = ciim_pkg::ST_REJECTED;
              state_next    = ciim_pkg::S_OUT;
            end else if (count == '0) begin
              state_next = ciim_pkg::S_LOAD_WR;
            end else begin
              state_next = ciim_pkg::S_RD;
            end
          end
          ciim_pkg::ACT_FRAME: begin
            if (count == '0) begin
              o_status_next = ciim_pkg::ST_UNKNOWN;
              state_next    = ciim_pkg::S_OUT;
            end else begin
              state_next = ciim_pkg::S_RD;
            end
          end
          ciim_pkg::ACT_TICK: begin
            state_next = scan_en ? ciim_pkg::S_RD : ciim_pkg::S_IDLE;
          end
          default: begin
            state_next = ciim_pkg::S_IDLE;
          end
        endcase
      end

      // read data of entry idx lands in rd_*
      ciim_pkg::S_RD: begin
        state_next = ciim_pkg::S_EVAL;
      end

      ciim_pkg::S_EVAL: begin
        case (act)
          ciim_pkg::ACT_LOAD: begin
            if (rd_id == cid) begin
              o_status_next = ciim_pkg::ST_REJECTED;
              state_next    = ciim_pkg::S_OUT;
            end else if (last_entry) begin
              state_next = ciim_pkg::S_LOAD_WR;
            end else begin
              idx_next   = idx + IW'(1);
              state_next = ciim_pkg::S_RD;
            end
          end
          ciim_pkg::ACT_FRAME: begin
            if (rd_id == cid) begin
              // matched: store arrival time, keep the previous one
              mem_we    = 1'b1;
              mem_wlast = now;
              acc_next  = rd_last;
              if (rd_last == '0) begin
                scan_en_next  = 1'b1;
                o_status_next = ciim_pkg::ST_FIRST;
                state_next    = ciim_pkg::S_OUT;
              end else begin
                state_next = ciim_pkg::S_GAP;
              end
            end else if (last_entry) begin
              o_status_next = ciim_pkg::ST_UNKNOWN;
              state_next    = ciim_pkg::S_OUT;
            end else begin
              idx_next   = idx + IW'(1);
              state_next = ciim_pkg::S_RD;
            end
          end
          default: begin
            // tick: silence of this entry
            sub_a      = now;
            sub_b      = rd_last;
            acc_next   = sub_diff;
            state_next = ciim_pkg::S_LIM;
          end
        endcase
      end

      // append the new entry, never seen
      ciim_pkg::S_LOAD_WR: begin
        mem_we        = 1'b1;
        mem_load      = 1'b1;
        mem_wa        = count[IW-1:0];
        mem_wlast     = '0;
        count_next    = count + CW'(1);
        o_status_next = ciim_pkg::ST_LOADED;
        state_next    = ciim_pkg::S_OUT;
      end

      // gap since previous frame; borrow means time went backwards
      ciim_pkg::S_GAP: begin
        sub_a = now;
        sub_b = acc;
        if (sub_borrow) begin
          o_status_next = ciim_pkg::ST_BACK;
          state_next    = ciim_pkg::S_OUT;
        end else begin
          acc_next   = sub_diff;
          state_next = ciim_pkg::S_MIN;
        end
      end

      // gap below minimum
      ciim_pkg::S_MIN: begin
        sub_a      = acc;
        sub_b      = ciim_pkg::TIME_W'(rd_min);
        band_next  = sub_borrow;
        state_next = ciim_pkg::S_MAX;
      end

      // gap above maximum
      ciim_pkg::S_MAX: begin
        sub_a          = ciim_pkg::TIME_W'(rd_max);
        sub_b          = acc;
        o_status_next  = (band || sub_borrow) ? ciim_pkg::ST_BAND : ciim_pkg::ST_OK;
        o_elapsed_next = acc;
        state_next     = ciim_pkg::S_OUT;
      end

      // silence against the limit; first walk counts, second clears/reports
      ciim_pkg::S_LIM: begin
        sub_a = ciim_pkg::TIME_W'(limit_ms);
        sub_b = acc;
        if (!pass2) begin
          hits_next = hits + CW'(hit);
          if (last_entry) begin
            idx_next = '0;
            if (hits_next == '0) begin
              state_next = ciim_pkg::S_IDLE;
            end else begin
              scan_en_next = 1'b0;
              pass2_next   = 1'b1;
              report_next  = (hits_next != count);
              state_next   = ciim_pkg::S_RD;
            end
          end else begin
            idx_next   = idx + IW'(1);
            state_next = ciim_pkg::S_RD;
          end
        end else begin
          if (hit) begin
            mem_we    = 1'b1;
            mem_wlast = '0;
          end
          if (hit && report) begin
            hits_next      = hits - CW'(1);
            o_status_next  = ciim_pkg::ST_SILENT;
            o_id_next      = rd_id;
            o_elapsed_next = acc;
            o_last_next    = (hits == CW'(1));
            state_next     = ciim_pkg::S_OUT;
          end else if (last_entry) begin
            state_next = ciim_pkg::S_IDLE;
          end else begin
            idx_next   = idx + IW'(1);
            state_next = ciim_pkg::S_RD;
          end
        end
      end

      // hold the result until taken; a non-final silent result resumes the walk
      ciim_pkg::S_OUT: begin
        if (!out_stall) begin
          if (o_last) begin
            state_next = ciim_pkg::S_IDLE;
          end else begin
            idx_next   = idx + IW'(1);
            state_next = ciim_pkg::S_RD;
          end
        end
      end

      default: begin
        state_next = ciim_pkg::S_IDLE;
      end
    endcase
  end

  // checks
  `CIIM_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(TABLE_DEPTH), "count past depth")
  `CIIM_ASSERT_NOW(a_out_blocks_in, out_valid, in_stall, "input open while a result waits")
  `CIIM_ASSERT_NEXT(a_accept_dispatch, in_valid && !in_stall, state == ciim_pkg::S_DISPATCH, "lost item")
  `CIIM_ASSERT_NOW(a_hits_bound, pass2, hits <= count, "silent count past entry count")

endmodule
